@@ src/alt_pkg.sv @@
// shared constants, codes and types for the arc length table lookup unit
`timescale 1ns / 1ps

package alt_pkg;

    // table geometry
    localparam int TABLE_LOG2 = 7;
    localparam int DEPTH      = 1 << TABLE_LOG2;
    localparam int AW         = TABLE_LOG2;
    localparam int FW         = TABLE_LOG2 + 1;
    localparam int LW         = 31;

    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    // iteration counts of the square root and of the divider
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 33;

    // datapath operation codes
    typedef logic [4:0] t_op;
    localparam t_op OP_IDLE   = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_FIRST  = 5'd2;
    localparam t_op OP_FULL   = 5'd3;
    localparam t_op OP_DIFF   = 5'd4;
    localparam t_op OP_SQX    = 5'd5;
    localparam t_op OP_SQY    = 5'd6;
    localparam t_op OP_SQRT   = 5'd7;
    localparam t_op OP_PWR    = 5'd8;
    localparam t_op OP_QEMPTY = 5'd9;
    localparam t_op OP_RD0    = 5'd10;
    localparam t_op OP_CHK0   = 5'd11;
    localparam t_op OP_RDN    = 5'd12;
    localparam t_op OP_CHKN   = 5'd13;
    localparam t_op OP_SETLO  = 5'd14;
    localparam t_op OP_RDMID  = 5'd15;
    localparam t_op OP_CHKMID = 5'd16;
    localparam t_op OP_RDP0   = 5'd17;
    localparam t_op OP_LATP0  = 5'd18;
    localparam t_op OP_LATP1  = 5'd19;
    localparam t_op OP_OUTP   = 5'd20;
    localparam t_op OP_IDIFF  = 5'd21;
    localparam t_op OP_MLO    = 5'd22;
    localparam t_op OP_MHI    = 5'd23;
    localparam t_op OP_DINIT  = 5'd24;
    localparam t_op OP_DSTEP  = 5'd25;
    localparam t_op OP_IFIN   = 5'd26;

    // result status codes
    typedef logic [1:0] t_status_code;
    localparam t_status_code ST_OK       = 2'd0;
    localparam t_status_code ST_NOT_FULL = 2'd1;
    localparam t_status_code ST_IGNORED  = 2'd2;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req;
        logic first;
        logic fill_zero;
        logic full;
        logic one_entry;
        logic d_le;
        logic d_ge;
        logic gap;
    } t_flags;

endpackage

@@ src/alt_ctrl.sv @@
// controller state machine for the arc length table lookup unit
`timescale 1ns / 1ps

module alt_ctrl import alt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_stall,
    input  t_flags i_flags,
    output t_cmd   o_cmd,
    output logic   o_busy,
    output logic   o_done
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_SQX   = 5'd2;
    localparam logic [4:0] S_SQY   = 5'd3;
    localparam logic [4:0] S_SQRT  = 5'd4;
    localparam logic [4:0] S_PWR   = 5'd5;
    localparam logic [4:0] S_CHK0  = 5'd6;
    localparam logic [4:0] S_RDN   = 5'd7;
    localparam logic [4:0] S_CHKN  = 5'd8;
    localparam logic [4:0] S_SETLO = 5'd9;
    localparam logic [4:0] S_PRDE  = 5'd10;
    localparam logic [4:0] S_POUT  = 5'd11;
    localparam logic [4:0] S_SRD   = 5'd12;
    localparam logic [4:0] S_SCHK  = 5'd13;
    localparam logic [4:0] S_PLAT0 = 5'd14;
    localparam logic [4:0] S_PLAT1 = 5'd15;
    localparam logic [4:0] S_IDIFF = 5'd16;
    localparam logic [4:0] S_MLO   = 5'd17;
    localparam logic [4:0] S_MHI   = 5'd18;
    localparam logic [4:0] S_DINIT = 5'd19;
    localparam logic [4:0] S_DSTEP = 5'd20;
    localparam logic [4:0] S_IFIN  = 5'd21;
    localparam logic [4:0] S_DONE  = 5'd22;

    logic [4:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_sel, n_sel;
    t_op        op;

    // state, step counter and coordinate select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    // next state and command
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        op      = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_flags.req) begin
                    if (i_flags.first || i_flags.fill_zero) begin
                        op      = OP_FIRST;
                        n_state = S_DONE;
                    end else if (i_flags.full) begin
                        op      = OP_FULL;
                        n_state = S_DONE;
                    end else begin
                        op      = OP_DIFF;
                        n_state = S_SQX;
                    end
                end else if (i_flags.fill_zero) begin
                    op      = OP_QEMPTY;
                    n_state = S_DONE;
                end else begin
                    op      = OP_RD0;
                    n_state = S_CHK0;
                end
            end
            S_SQX: begin
                op      = OP_SQX;
                n_state = S_SQY;
            end
            S_SQY: begin
                op      = OP_SQY;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                op    = OP_SQRT;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                op      = OP_PWR;
                n_state = S_DONE;
            end
            S_CHK0: begin
                op = OP_CHK0;
                if (i_flags.one_entry || i_flags.d_le) begin
                    n_state = S_PRDE;
                end else begin
                    n_state = S_RDN;
                end
            end
            S_RDN: begin
                op      = OP_RDN;
                n_state = S_CHKN;
            end
            S_CHKN: begin
                op = OP_CHKN;
                if (i_flags.d_ge) begin
                    n_state = S_SETLO;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SETLO: begin
                op      = OP_SETLO;
                n_state = S_PRDE;
            end
            S_PRDE: begin
                op      = OP_RDP0;
                n_state = S_POUT;
            end
            S_POUT: begin
                op      = OP_OUTP;
                n_state = S_DONE;
            end
            S_SRD: begin
                if (i_flags.gap) begin
                    op      = OP_RDMID;
                    n_state = S_SCHK;
                end else begin
                    op      = OP_RDP0;
                    n_state = S_PLAT0;
                end
            end
            S_SCHK: begin
                op      = OP_CHKMID;
                n_state = S_SRD;
            end
            S_PLAT0: begin
                op      = OP_LATP0;
                n_state = S_PLAT1;
            end
            S_PLAT1: begin
                op      = OP_LATP1;
                n_sel   = 1'b0;
                n_state = S_IDIFF;
            end
            S_IDIFF: begin
                op      = OP_IDIFF;
                n_state = S_MLO;
            end
            S_MLO: begin
                op      = OP_MLO;
                n_state = S_MHI;
            end
            S_MHI: begin
                op      = OP_MHI;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                op      = OP_DINIT;
                n_cnt   = '0;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                op    = OP_DSTEP;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = S_IFIN;
                end
            end
            S_IFIN: begin
                op = OP_IFIN;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_IDIFF;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.op  = op;
    assign o_cmd.sel = r_sel;
    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE);

endmodule

@@ src/alt_dpath.sv @@
// datapath: tables, running length, square root, multiplier and divider
`timescale 1ns / 1ps

module alt_dpath import alt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_req_type,
    input  logic               i_first_sample,
    input  logic signed [31:0] i_sample_x,
    input  logic signed [31:0] i_sample_y,
    input  logic [LW-1:0]      i_query_distance,
    output t_flags             o_flags,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [LW-1:0]      o_total_length,
    output logic [1:0]         o_status
);

    // tables
    logic [LW-1:0] len_mem [DEPTH];
    logic [63:0]   pt_mem  [DEPTH];

    // latched transaction
    logic               r_req, r_first;
    logic signed [31:0] r_x, r_y;
    logic [LW-1:0]      r_d;

    // path state
    logic [FW-1:0]      r_fill;
    logic [LW-1:0]      r_running;
    logic signed [31:0] r_prev_x, r_prev_y;

    // arithmetic registers
    logic [30:0]        r_ax, r_ay;
    logic               r_big;
    logic [63:0]        r_acc;
    logic [34:0]        r_rem;
    logic [31:0]        r_root;
    logic [30:0]        r_drem;
    logic [32:0]        r_q;
    logic [32:0]        r_mag;
    logic               r_neg;
    logic [LW-1:0]      r_num, r_den;

    // search registers
    logic [AW-1:0]      r_lo, r_hi;
    logic [LW-1:0]      r_l0, r_l1;
    logic [LW-1:0]      r_rd_len;
    logic [63:0]        r_rd_pt;
    logic [63:0]        r_p0, r_p1;

    // result registers
    logic signed [31:0] r_ox, r_oy;
    t_status_code       r_status;

    logic [AW-1:0]      rd_addr, mid;
    logic [31:0]        mul_a;
    logic [30:0]        mul_b;
    logic [62:0]        prod;
    logic [32:0]        dx, dy, adx, ady;
    logic [34:0]        rem_sh, trial;
    logic [LW-1:0]      seg, new_run;
    logic [LW:0]        run_sum;
    logic [FW-1:0]      fill_inc;
    logic [31:0]        drem_sh;
    logic               dge;
    logic signed [31:0] c0, c1;
    logic [32:0]        cdiff, cres;

    assign mid = r_lo + AW'((r_hi - r_lo) >> 1);

    // table read address
    always_comb begin
        unique case (i_cmd.op)
            OP_RDN:   rd_addr = r_hi;
            OP_RDMID: rd_addr = mid;
            OP_RDP0:  rd_addr = r_lo;
            OP_LATP0: rd_addr = r_hi;
            default:  rd_addr = '0;
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIRST) begin
            len_mem[0] <= '0;
            pt_mem[0]  <= {r_y, r_x};
        end else if (i_cmd.op == OP_PWR) begin
            len_mem[r_fill[AW-1:0]] <= new_run;
            pt_mem[r_fill[AW-1:0]]  <= {r_y, r_x};
        end
        r_rd_len <= len_mem[rd_addr];
        r_rd_pt  <= pt_mem[rd_addr];
    end

    // shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            OP_SQX: begin
                mul_a = {1'b0, r_ax};
                mul_b = r_ax;
            end
            OP_SQY: begin
                mul_a = {1'b0, r_ay};
                mul_b = r_ay;
            end
            OP_MLO: begin
                mul_a = {15'd0, r_mag[16:0]};
                mul_b = r_num;
            end
            default: begin
                mul_a = {16'd0, r_mag[32:17]};
                mul_b = r_num;
            end
        endcase
    end
    assign prod = 63'(mul_a * mul_b);

    // point differences for a push
    assign dx  = {r_x[31], r_x} - {r_prev_x[31], r_prev_x};
    assign dy  = {r_y[31], r_y} - {r_prev_y[31], r_prev_y};
    assign adx = dx[32] ? (~dx + 33'd1) : dx;
    assign ady = dy[32] ? (~dy + 33'd1) : dy;

    // one square root step, two radicand bits
    assign rem_sh = {r_rem[32:0], r_acc[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};

    // length accumulation with saturation
    assign seg      = (r_big || r_root[31]) ? LEN_MAX : r_root[LW-1:0];
    assign run_sum  = {1'b0, r_running} + {1'b0, seg};
    assign new_run  = run_sum[LW] ? LEN_MAX : run_sum[LW-1:0];
    assign fill_inc = r_fill + FW'(1);

    // one divider step
    assign drem_sh = {r_drem, r_q[32]};
    assign dge     = (drem_sh >= {1'b0, r_den});

    // interpolation of the selected coordinate
    assign c0    = i_cmd.sel ? r_p0[63:32] : r_p0[31:0];
    assign c1    = i_cmd.sel ? r_p1[63:32] : r_p1[31:0];
    assign cdiff = {c1[31], c1} - {c0[31], c0};
    assign cres  = r_neg ? ({c0[31], c0} - r_q) : ({c0[31], c0} + r_q);

    // path control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_running <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
        end else if (i_cmd.op == OP_FIRST) begin
            r_fill    <= FW'(1);
            r_running <= '0;
            r_prev_x  <= r_x;
            r_prev_y  <= r_y;
        end else if (i_cmd.op == OP_PWR) begin
            r_fill    <= fill_inc;
            r_running <= new_run;
            r_prev_x  <= r_x;
            r_prev_y  <= r_y;
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_req   <= i_req_type;
                r_first <= i_first_sample;
                r_x     <= i_sample_x;
                r_y     <= i_sample_y;
                r_d     <= i_query_distance;
            end
            OP_FIRST: begin
                r_ox     <= r_x;
                r_oy     <= r_y;
                r_status <= (DEPTH == 1) ? ST_OK : ST_NOT_FULL;
            end
            OP_FULL: begin
                r_ox     <= r_x;
                r_oy     <= r_y;
                r_status <= ST_IGNORED;
            end
            OP_DIFF: begin
                r_ax  <= adx[30:0];
                r_ay  <= ady[30:0];
                r_big <= adx[32] | adx[31] | ady[32] | ady[31];
            end
            OP_SQX: begin
                r_acc <= {1'b0, prod};
            end
            OP_SQY: begin
                r_acc  <= r_acc + {1'b0, prod};
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_acc <= {r_acc[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            OP_PWR: begin
                r_ox     <= r_x;
                r_oy     <= r_y;
                r_status <= (fill_inc == FW'(DEPTH)) ? ST_OK : ST_NOT_FULL;
            end
            OP_QEMPTY: begin
                r_ox     <= '0;
                r_oy     <= '0;
                r_status <= ST_NOT_FULL;
            end
            OP_RD0: begin
                r_lo     <= '0;
                r_hi     <= AW'(r_fill - FW'(1));
                r_status <= (r_fill == FW'(DEPTH)) ? ST_OK : ST_NOT_FULL;
            end
            OP_CHK0: begin
                r_l0 <= r_rd_len;
            end
            OP_CHKN: begin
                r_l1 <= r_rd_len;
            end
            OP_SETLO: begin
                r_lo <= r_hi;
            end
            OP_CHKMID: begin
                if (r_rd_len <= r_d) begin
                    r_lo <= mid;
                    r_l0 <= r_rd_len;
                end else begin
                    r_hi <= mid;
                    r_l1 <= r_rd_len;
                end
            end
            OP_LATP0: begin
                r_p0 <= r_rd_pt;
            end
            OP_LATP1: begin
                r_p1 <= r_rd_pt;
            end
            OP_OUTP: begin
                r_ox <= r_rd_pt[31:0];
                r_oy <= r_rd_pt[63:32];
            end
            OP_IDIFF: begin
                r_neg <= cdiff[32];
                r_mag <= cdiff[32] ? (~cdiff + 33'd1) : cdiff;
                r_num <= r_d - r_l0;
                r_den <= r_l1 - r_l0;
            end
            OP_MLO: begin
                r_acc <= {1'b0, prod};
            end
            OP_MHI: begin
                r_acc <= r_acc + {prod[46:0], 17'd0};
            end
            OP_DINIT: begin
                r_drem <= r_acc[63:33];
                r_q    <= r_acc[32:0];
            end
            OP_DSTEP: begin
                r_drem <= dge ? 31'(drem_sh - {1'b0, r_den}) : drem_sh[30:0];
                r_q    <= {r_q[31:0], dge};
            end
            OP_IFIN: begin
                if (i_cmd.sel) begin
                    r_oy <= cres[31:0];
                end else begin
                    r_ox <= cres[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    // flags for the controller
    assign o_flags.req       = r_req;
    assign o_flags.first     = r_first;
    assign o_flags.fill_zero = (r_fill == '0);
    assign o_flags.full      = (r_fill == FW'(DEPTH));
    assign o_flags.one_entry = (r_fill == FW'(1));
    assign o_flags.d_le      = (r_d <= r_rd_len);
    assign o_flags.d_ge      = (r_d >= r_rd_len);
    assign o_flags.gap       = ((r_hi - r_lo) > AW'(1));

    assign o_pos_x        = r_ox;
    assign o_pos_y        = r_oy;
    assign o_total_length = r_running;
    assign o_status       = r_status;

endmodule

@@ src/arc_length_table_lookup_unit.sv @@
// top level of the arc length table lookup unit
`timescale 1ns / 1ps

// Maps a distance along a sampled 2-D path to a position; positions are signed Q16.16, distances unsigned Q15.16.
// A push stores one point (at most 128); a first-flagged push restarts the
// path. One transaction is worked on at a time and its result is held until
// taken. A first push, a push into a full table and a query of an empty
// table go straight from dispatch to the result; any other push runs the
// 32-step square root that gives the segment length. A query at a table end
// point reads the end entries; one that interpolates runs the binary search
// over the single-port table (a read and a check per level) and the 33-step
// divider, once for x and once for y.
module arc_length_table_lookup_unit import alt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic               i_first_sample,
    input  logic signed [31:0] i_sample_x,
    input  logic signed [31:0] i_sample_y,
    input  logic [LW-1:0]      i_query_distance,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [LW-1:0]      o_total_length,
    output logic [1:0]         o_status
);

    t_cmd   cmd;
    t_flags flags;
    logic   busy;

    // sequencer
    alt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_flags (flags),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    // tables and arithmetic
    alt_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_first_sample   (i_first_sample),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .i_query_distance (i_query_distance),
        .o_flags          (flags),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_total_length   (o_total_length),
        .o_status         (o_status)
    );

    assign o_stall = busy;

    // an accepted transaction never shows a result in the next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("result valid right after acceptance");

    // input is held off while a result is pending
    a_stall_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input not stalled while result pending");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NOT_FULL ||
                     o_status == ST_IGNORED))
        else $error("undefined status code");

endmodule
